### hw/rtl/ssg_pkg.sv
package ssg_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_MOTORS_DEF = 3;
  localparam int unsigned TICK_RATE_DEF  = 1984;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned PPS_W   = 11;
  localparam int unsigned TOTAL_W = 16;
  localparam int unsigned CNT_W   = 8;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned OUT_TUSER_W = 1;
  localparam int unsigned OUT_USED_W  = 6;

  // Divider: 16-bit dividend, one quotient bit per cycle
  localparam int unsigned DVD_W      = 16;
  localparam int unsigned REM_W      = PPS_W + 1;
  localparam int unsigned STEP_CNT_W = $clog2(DVD_W);

  localparam logic [PPS_W-1:0]   PPS_MIN       = 11'd10;
  localparam logic [PPS_W-1:0]   PPS_MAX       = 11'd1984;
  localparam logic [TOTAL_W-1:0] STEPS_FOREVER = 16'hFFFF;
  localparam logic [CNT_W-1:0]   RELOAD_MAX    = 8'hFF;
  localparam logic [CNT_W-1:0]   RELOAD_MIN    = 8'h01;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_START   = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_ALL_OFF = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic exec;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_div;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/ssg_ctrl.sv
module ssg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ssg_pkg::dp_status_t status,
  output ssg_pkg::dp_cmd_t    cmd
);
  import ssg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC
  } state_t;

  localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DVD_W - 1);

  state_t                  state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   step_r, step_nxt;
  logic                    ready_r, ready_nxt;

  assign in_tready = ready_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ready_nxt = ready_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        ready_nxt = 1'b1;
        if (in_tvalid && ready_r) begin
          cmd.load  = 1'b1;
          ready_nxt = 1'b0;
          step_nxt  = '0;
          state_nxt = status.start_div ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_LAST) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        // wait for room in the output register
        if (status.out_free) begin
          cmd.exec  = 1'b1;
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        ready_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

### hw/rtl/ssg_datapath.sv
module ssg_datapath #(
  parameter int unsigned NUM_MOTORS = ssg_pkg::NUM_MOTORS_DEF,
  parameter int unsigned TICK_RATE  = ssg_pkg::TICK_RATE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssg_pkg::cmd_t               in_cmd,
  input  logic [ssg_pkg::SEL_W-1:0]   in_motor_sel,
  input  logic [ssg_pkg::MODE_W-1:0]  in_microstep_mode,
  input  logic                        in_forward,
  input  logic [ssg_pkg::PPS_W-1:0]   in_pulses_per_sec,
  input  logic [ssg_pkg::TOTAL_W-1:0] in_step_total,
  input  ssg_pkg::dp_cmd_t            cmd,
  output ssg_pkg::dp_status_t         status,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic                        out_step_pulse,
  output logic [ssg_pkg::SEL_W-1:0]   out_pulse_motor,
  output logic [ssg_pkg::MODE_W-1:0]  out_microstep_lines,
  output logic                        out_direction_line,
  output logic                        out_power_enable
);
  import ssg_pkg::*;

  localparam int unsigned      IDX_W    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(TICK_RATE);

  // Latched item
  cmd_t               cmd_r;
  logic [SEL_W-1:0]   sel_r;
  logic               sel_ok_r;
  logic [MODE_W-1:0]  mode_r;
  logic               fwd_r;
  logic [TOTAL_W-1:0] total_r;

  // Restoring divider
  logic [PPS_W-1:0]   dvs_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [PPS_W-1:0]   rem_r;
  logic [DVD_W-1:0]   quo_r;

  // Channel state
  logic [TOTAL_W-1:0] steps_r  [NUM_MOTORS];
  logic [CNT_W-1:0]   cnt_r    [NUM_MOTORS];
  logic [CNT_W-1:0]   reload_r [NUM_MOTORS];
  logic [MODE_W-1:0]  mstep_r  [NUM_MOTORS];
  logic               dir_r    [NUM_MOTORS];
  logic               power_r;

  // Result register
  logic               out_valid_r;
  logic               out_pulse_r;
  logic [SEL_W-1:0]   out_motor_r;
  logic [MODE_W-1:0]  out_mstep_r;
  logic               out_dir_r;
  logic               out_power_r;

  logic               in_sel_ok;
  logic [PPS_W-1:0]   pps_clamped;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   rem_sub;
  logic               rem_ge;
  logic [CNT_W-1:0]   reload_q;
  logic [IDX_W-1:0]   idx;
  logic [TOTAL_W-1:0] cur_steps;
  logic [CNT_W-1:0]   cnt_inc;
  logic               running;
  logic               hit;
  logic               tick_pulse;
  logic               power_nxt;

  assign in_sel_ok = (32'(in_motor_sel) < 32'(NUM_MOTORS));

  assign status.start_div = (in_cmd == CMD_START) && in_sel_ok;
  assign status.out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (in_pulses_per_sec < PPS_MIN)      pps_clamped = PPS_MIN;
    else if (in_pulses_per_sec > PPS_MAX) pps_clamped = PPS_MAX;
    else                                  pps_clamped = in_pulses_per_sec;
  end

  // One quotient bit per step
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // Saturate the quotient into the 8-bit reload
  always_comb begin
    if (quo_r == '0)                   reload_q = RELOAD_MIN;
    else if (|quo_r[DVD_W-1:CNT_W])    reload_q = RELOAD_MAX;
    else                               reload_q = quo_r[CNT_W-1:0];
  end

  assign idx        = IDX_W'(sel_r);
  assign cur_steps  = steps_r[idx];
  assign cnt_inc    = cnt_r[idx] + 1'b1;
  assign running    = sel_ok_r && (cur_steps != '0);
  assign hit        = (cnt_inc == reload_r[idx]);
  assign tick_pulse = (cmd_r == CMD_TICK) && running && hit;

  always_comb begin
    power_nxt = power_r;
    if ((cmd_r == CMD_START) && sel_ok_r) power_nxt = 1'b1;
    else if (cmd_r == CMD_ALL_OFF)        power_nxt = 1'b0;
  end

  // Item latch, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_cmd;
      sel_r    <= in_motor_sel;
      sel_ok_r <= in_sel_ok;
      mode_r   <= in_microstep_mode;
      fwd_r    <= in_forward;
      total_r  <= in_step_total;
      dvs_r    <= pps_clamped;
      dvd_r    <= DIVIDEND;
      rem_r    <= '0;
      quo_r    <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_ge ? rem_sub[PPS_W-1:0] : rem_sh[PPS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], rem_ge};
    end
    if (cmd.exec) begin
      out_pulse_r <= tick_pulse;
      out_motor_r <= tick_pulse ? sel_r : '0;
      out_mstep_r <= tick_pulse ? mstep_r[idx] : '0;
      out_dir_r   <= tick_pulse ? dir_r[idx] : 1'b0;
      out_power_r <= power_nxt;
    end
  end

  // Channel state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
        steps_r[m]  <= '0;
        cnt_r[m]    <= '0;
        reload_r[m] <= '0;
        mstep_r[m]  <= '0;
        dir_r[m]    <= 1'b0;
      end
      power_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (cmd.exec) begin
        power_r <= power_nxt;
        unique case (cmd_r)
          CMD_TICK: begin
            if (running) begin
              cnt_r[idx] <= hit ? '0 : cnt_inc;
              if (hit && (cur_steps != STEPS_FOREVER)) steps_r[idx] <= cur_steps - 1'b1;
            end
          end
          CMD_START: begin
            if (sel_ok_r) begin
              mstep_r[idx]  <= mode_r;
              dir_r[idx]    <= fwd_r;
              reload_r[idx] <= reload_q;
              cnt_r[idx]    <= '0;
              steps_r[idx]  <= total_r;
            end
          end
          CMD_STOP: begin
            if (sel_ok_r) steps_r[idx] <= '0;
          end
          CMD_ALL_OFF: begin
            for (int m = 0; m < NUM_MOTORS; m++) steps_r[m] <= '0;
          end
        endcase
      end
    end
  end

  assign out_tvalid          = out_valid_r;
  assign out_step_pulse      = out_pulse_r;
  assign out_pulse_motor     = out_motor_r;
  assign out_microstep_lines = out_mstep_r;
  assign out_direction_line  = out_dir_r;
  assign out_power_enable    = out_power_r;

endmodule

### hw/rtl/stepper_step_pulse_generator_top.sv
// Step pulse generator for up to NUM_MOTORS stepper channels. Each input item is one command
// (tick, start, stop or all-off) and yields exactly one result item, which reports whether a
// step pulse went out, on which motor, with the latched microstep and direction bits, and the
// driver power state after the command. A start clamps the rate to 10..1984 pulses per second
// and sets the channel divider to TICK_RATE / rate, saturated to 1..255; a step_total of 65535
// runs the channel forever. Sequence: a tick, stop or all-off goes from acceptance through the
// execute state to the result, and no further item is taken until that result is written; a
// start on a valid channel first passes the divide state, where the restoring divider produces
// one quotient bit per cycle over its 16-bit dividend. The result sits in an output register,
// so the next item is taken while an earlier result still waits on out_tready.
module stepper_step_pulse_generator_top #(
  parameter int unsigned NUM_MOTORS = ssg_pkg::NUM_MOTORS_DEF,
  parameter int unsigned TICK_RATE  = ssg_pkg::TICK_RATE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input item
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] cmd
  input  logic [ssg_pkg::IN_TUSER_W-1:0]  in_tuser,
  // [1:0] motor_sel, [3:2] microstep_mode, [4] forward,
  // [15:5] pulses_per_sec, [31:16] step_total
  input  logic [ssg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] step_pulse
  output logic [ssg_pkg::OUT_TUSER_W-1:0] out_tuser,
  // [1:0] pulse_motor, [3:2] microstep_lines, [4] direction_line,
  // [5] power_enable, [7:6] zero
  output logic [ssg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ssg_pkg::*;

  dp_cmd_t            dp_cmd;
  dp_status_t         dp_status;

  logic               step_pulse;
  logic [SEL_W-1:0]   pulse_motor;
  logic [MODE_W-1:0]  microstep_lines;
  logic               direction_line;
  logic               power_enable;

  // Sequence load, divide and execute
  ssg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Unpack the item straight into the datapath; it latches on load
  ssg_datapath #(
    .NUM_MOTORS (NUM_MOTORS),
    .TICK_RATE  (TICK_RATE)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_cmd              (cmd_t'(in_tuser[CMD_W-1:0])),
    .in_motor_sel        (in_tdata[1:0]),
    .in_microstep_mode   (in_tdata[3:2]),
    .in_forward          (in_tdata[4]),
    .in_pulses_per_sec   (in_tdata[15:5]),
    .in_step_total       (in_tdata[31:16]),
    .cmd                 (dp_cmd),
    .status              (dp_status),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_step_pulse      (step_pulse),
    .out_pulse_motor     (pulse_motor),
    .out_microstep_lines (microstep_lines),
    .out_direction_line  (direction_line),
    .out_power_enable    (power_enable)
  );

  // Pack the result, padding to whole bytes
  assign out_tuser = step_pulse;
  assign out_tdata = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                      power_enable, direction_line, microstep_lines, pulse_motor};

endmodule

### hw/rtl/ssg_checker.sv
module ssg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [ssg_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic [ssg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ssg_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic [ssg_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // One item at a time: ready drops after each acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in flight");

  // No pulse means all pulse fields are zero
  a_no_pulse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[4:0] == 5'd0)
    else $error("pulse fields set without a pulse");

  // A pulse can only come from a powered channel
  a_pulse_powered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[5])
    else $error("pulse issued with power down");

endmodule

bind stepper_step_pulse_generator_top ssg_checker u_ssg_checker (.*);
